/* design/ntc_pkg.sv */
// package for the numeric type cast unit: mode codes, mode table, widths
// no dependencies
package ntc_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned ModeW = 5;

  typedef enum logic [ModeW-1:0] {
    M_F32_I64 = 5'd0,  M_F32_I32 = 5'd1,  M_F32_I16 = 5'd2,  M_F32_I8 = 5'd3,
    M_F32_F32 = 5'd4,  M_I32_F32 = 5'd5,  M_I32_I8 = 5'd6,   M_I32_I16 = 5'd7,
    M_I32_I64 = 5'd8,  M_I16_F32 = 5'd9,  M_I16_I32 = 5'd10, M_I8_F32 = 5'd11,
    M_I8_I16 = 5'd12,  M_I8_I32 = 5'd13,  M_U8_F32 = 5'd14,  M_U8_I32 = 5'd15,
    M_U8_I64 = 5'd16,  M_I64_I32 = 5'd17, M_I64_U32 = 5'd18, M_I64_F32 = 5'd19,
    M_U32_I64 = 5'd20, M_NONE_LO = 5'd21, M_NONE_HI = 5'd31
  } cast_mode_t;

  typedef enum logic [1:0] {
    KIND_F2I = 2'd0,
    KIND_F2F = 2'd1,
    KIND_I2F = 2'd2,
    KIND_I2I = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } wsel_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    wsel_t from_w;
    logic  from_s;
    wsel_t to_w;
    logic  to_s;
  } mode_desc_t;

  function automatic mode_desc_t mode_lookup(input logic [ModeW-1:0] m);
    mode_desc_t d;
    d = '{valid: 1'b1, kind: KIND_F2I, from_w: W32, from_s: 1'b1, to_w: W64, to_s: 1'b1};
    case (m)
      M_F32_I64: d.to_w = W64;
      M_F32_I32: d.to_w = W32;
      M_F32_I16: d.to_w = W16;
      M_F32_I8:  d.to_w = W8;
      M_F32_F32: begin d.kind = KIND_F2F; d.to_w = W32; end
      M_I32_F32: begin d.kind = KIND_I2F; d.to_w = W32; end
      M_I32_I8:  begin d.kind = KIND_I2I; d.to_w = W8; end
      M_I32_I16: begin d.kind = KIND_I2I; d.to_w = W16; end
      M_I32_I64: begin d.kind = KIND_I2I; d.to_w = W64; end
      M_I16_F32: begin d.kind = KIND_I2F; d.from_w = W16; d.to_w = W32; end
      M_I16_I32: begin d.kind = KIND_I2I; d.from_w = W16; d.to_w = W32; end
      M_I8_F32:  begin d.kind = KIND_I2F; d.from_w = W8; d.to_w = W32; end
      M_I8_I16:  begin d.kind = KIND_I2I; d.from_w = W8; d.to_w = W16; end
      M_I8_I32:  begin d.kind = KIND_I2I; d.from_w = W8; d.to_w = W32; end
      M_U8_F32:  begin d.kind = KIND_I2F; d.from_w = W8; d.from_s = 1'b0; d.to_w = W32; end
      M_U8_I32:  begin d.kind = KIND_I2I; d.from_w = W8; d.from_s = 1'b0; d.to_w = W32; end
      M_U8_I64:  begin d.kind = KIND_I2I; d.from_w = W8; d.from_s = 1'b0; d.to_w = W64; end
      M_I64_I32: begin d.kind = KIND_I2I; d.from_w = W64; d.to_w = W32; end
      M_I64_U32: begin
        d.kind = KIND_I2I; d.from_w = W64; d.to_w = W32; d.to_s = 1'b0;
      end
      M_I64_F32: begin d.kind = KIND_I2F; d.from_w = W64; d.to_w = W32; end
      M_U32_I64: begin d.kind = KIND_I2I; d.from_s = 1'b0; d.to_w = W64; end
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

  // sign- or zero-extend the low field of the given width
  function automatic logic [DataW-1:0] extend(input logic [DataW-1:0] v, input wsel_t w,
                                              input logic s);
    logic [DataW-1:0] r;
    case (w)
      W8:      r = {{56{s & v[7]}}, v[7:0]};
      W16:     r = {{48{s & v[15]}}, v[15:0]};
      W32:     r = {{32{s & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* design/ntc_stream_if.sv */
// valid/ready stream channel carrying one 64-bit word and a flag
// depends on ntc_pkg
interface ntc_stream_if import ntc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] bits;
  logic             flag;

  modport source (output valid, output bits, output flag, input ready);
  modport sink   (input valid, input bits, input flag, output ready);
endinterface

/* design/numeric_type_cast_unit.sv */
// numeric type cast unit: float32 <-> integer and integer <-> integer element converter, top level
// depends on ntc_pkg, ntc_stream_if, ntc_convert
//
// usage:
//   in_ch carries one 64-bit source word per request; out_ch returns the
//   converted word plus an out_of_range flag, one result per request.
//   cfg_we/cfg_wdata write the 5-bit cast mode; write it only while idle.
//   the input word is registered, converted by one pass of combinational
//   logic, and held in an output register; throughput is one request per
//   cycle while the receiver does not stall.
//   the input and output registers form a two-entry pipe; ready drops only
//   when both hold a request and the receiver stalls, so a stall ripples
//   back one stage at a time and nothing is lost.
//   reset (rst_n low, synchronous) empties both stages and sets the mode
//   to 0 (float32 to int64).
//   modes 21..31 give a zero result with the flag clear.
module numeric_type_cast_unit import ntc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [ModeW-1:0] cfg_wdata,
  ntc_stream_if.sink       in_ch,
  ntc_stream_if.source     out_ch
);

  logic [ModeW-1:0] mode_r;
  logic             s1_vld_r;
  logic [DataW-1:0] s1_src_r;
  logic             s2_vld_r;
  logic [DataW-1:0] s2_res_r;
  logic             s2_flag_r;
  logic             s2_free;
  logic             s1_free;
  logic [DataW-1:0] conv_res;
  logic             conv_flag;
  mode_desc_t       desc;

  assign desc    = mode_lookup(mode_r);
  assign s2_free = !s2_vld_r || out_ch.ready;
  assign s1_free = !s1_vld_r || s2_free;
  assign in_ch.ready = s1_free;

  ntc_convert u_conv (
    .desc (desc),
    .src  (s1_src_r),
    .res  (conv_res),
    .flag (conv_flag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      if (s1_free) s1_vld_r <= in_ch.valid;
      if (s2_free) s2_vld_r <= s1_vld_r;
    end
    if (s1_free && in_ch.valid) s1_src_r <= in_ch.bits;
    if (s2_free && s1_vld_r) begin
      s2_res_r  <= conv_res;
      s2_flag_r <= conv_flag;
    end
  end

  assign out_ch.valid = s2_vld_r;
  assign out_ch.bits  = s2_res_r;
  assign out_ch.flag  = s2_flag_r;

  // a stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.bits))
    else $error("result changed under stall");

  // ready low only when both stages full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_vld_r && s2_vld_r)
    else $error("ready low with free stage");

  // accepted request is in stage one next cycle
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_vld_r)
    else $error("accepted request lost");

endmodule

/* design/ntc_convert.sv */
// combinational conversion datapath for one element
// depends on ntc_pkg
module ntc_convert import ntc_pkg::*; (
  input  mode_desc_t       desc,
  input  logic [DataW-1:0] src,
  output logic [DataW-1:0] res,
  output logic             flag
);

  logic [DataW-1:0] v;
  // float to int
  logic             f_neg;
  logic [7:0]       f_ex;
  logic [22:0]      f_man;
  logic [DataW-1:0] f_mag;
  logic [DataW-1:0] f_maxpos;
  logic [DataW-1:0] f_negmag;
  logic [DataW-1:0] f2i_res;
  logic             f2i_flag;
  logic [7:0]       f_e;
  // int to float
  logic             i_neg;
  logic [DataW-1:0] i_mag;
  logic [5:0]       i_p;
  logic [DataW-1:0] i_norm;
  logic [24:0]      i_keep;
  logic             i_rnd;
  logic [7:0]       i_exp;
  logic [31:0]      i2f_res;

  always_comb begin
    v = extend(src, desc.from_w, desc.from_s);

    f_neg = src[31];
    f_ex  = src[30:23];
    f_man = src[22:0];
    f_e   = f_ex - 8'd127;
    case (desc.to_w)
      W8:      f_maxpos = 64'h7F;
      W16:     f_maxpos = 64'h7FFF;
      W32:     f_maxpos = 64'h7FFF_FFFF;
      default: f_maxpos = 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
    f_negmag = f_maxpos + 64'd1;
    if (f_ex >= 8'd191) begin
      f_mag = '1;
    end else if (f_e >= 8'd23) begin
      f_mag = {40'd0, 1'b1, f_man} << f_e[5:0] - 6'd23;
    end else begin
      f_mag = {40'd0, 1'b1, f_man} >> (6'd23 - f_e[5:0]);
    end
    f2i_flag = 1'b0;
    if (f_ex == 8'hFF && f_man != 23'd0) begin
      f2i_res  = '0;
      f2i_flag = 1'b1;
    end else if (f_ex < 8'd127) begin
      f2i_res = '0;
    end else if (!f_neg) begin
      f2i_flag = f_mag > f_maxpos;
      f2i_res  = f2i_flag ? f_maxpos : f_mag;
    end else begin
      f2i_flag = f_mag > f_negmag;
      f2i_res  = f2i_flag ? -f_negmag : -f_mag;
    end

    i_neg = desc.from_s & v[63];
    i_mag = i_neg ? -v : v;
    i_p   = '0;
    for (int i = 0; i < 64; i++) begin
      if (i_mag[i]) i_p = 6'(i);
    end
    i_norm = i_mag << (6'd63 - i_p);
    // bits 63..40 kept, 39 round, rest sticky
    i_rnd  = i_norm[39] & ((|i_norm[38:0]) | i_norm[40]);
    i_keep = {1'b0, i_norm[63:40]} + {24'd0, i_rnd};
    i_exp  = {2'b00, i_p} + 8'd127 + {7'd0, i_keep[24]};
    i2f_res = (i_mag == '0) ? 32'd0
            : {i_neg, i_exp, i_keep[24] ? i_keep[23:1] : i_keep[22:0]};

    res  = '0;
    flag = 1'b0;
    if (desc.valid) begin
      case (desc.kind)
        KIND_F2I: begin res = f2i_res; flag = f2i_flag; end
        KIND_F2F: res = {32'd0, src[31:0]};
        KIND_I2F: res = {32'd0, i2f_res};
        default:  res = extend(v, desc.to_w, desc.to_s);
      endcase
    end
  end

endmodule
